/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the frame rate meter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/mafrm_pkg.sv */
// Package for the moving-average frame rate meter: widths, reset values,
// register indexes and the divider handshake types. Depends on nothing.
package mafrm_pkg;

   // Window depth and derived widths
   localparam int MAX_SAMPLES = 256;
   localparam int PTR_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int TIME_W      = 32;
   localparam int WIN_W       = 9;
   localparam int SUM_W       = TIME_W + PTR_W;
   localparam int FRAC_W      = 8;
   localparam int RATE_W      = 48;
   localparam int PROD_W      = CNT_W + TIME_W;
   localparam int NUM_W       = PROD_W + FRAC_W;
   localparam int DIV_W       = (NUM_W > RATE_W) ? NUM_W : RATE_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'd1;

   // Register reset values
   localparam logic [WIN_W-1:0]  WINDOW_RESET = 9'd16;
   localparam logic [TIME_W-1:0] TICKS_RESET  = 32'd1000;

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

/* sv/mafrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mafrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mafrm_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mafrm_pkg.
module mafrm_div
   import mafrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [SUM_W-1:0]  divisor,
   output div_sts_type       sts,
   output logic [DIV_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dq_ff, dq_in;
   logic [SUM_W:0]       rem_shift;
   logic [SUM_W:0]       diff;

   // Trial subtract of the divisor from the shifted remainder
   assign rem_shift = {rem_ff, dq_ff[DIV_W-1]};
   assign diff      = rem_shift - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      if (ctl.start) begin
         // Load the dividend and clear the remainder
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         dq_in   = dividend;
      end else if (busy_ff) begin
         // Retire one quotient bit
         if (!diff[SUM_W]) begin
            rem_in = diff[SUM_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[SUM_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = dq_ff;

endmodule

/* sv/moving_average_frame_rate_meter.sv */
// Moving-average frame rate meter. Each accepted timestamp transaction yields
// one result. For a normal event the interval memory is read at the accepting
// edge. The update state then does the window update and the n*ticks multiply,
// the start state loads the divider, and the bit-serial divider works out the
// DIV_W (49) bit quotient. The quotient is then captured and saturated, and the
// finish state loads the output register. The first event after reset and an
// event with a zero delta go straight from acceptance to the finish state. The
// block accepts no new event until the previous result is in the output
// register; that register may still wait on rsp_ready while the next event
// runs. The interval memory needs no clearing pass: a fill count marks which
// slots were written since reset or the last window_size write, and unwritten
// slots read as zero.
// Depends on mafrm_pkg, mafrm_ram, mafrm_div and assert_macros.svh.
`include "assert_macros.svh"

module moving_average_frame_rate_meter
   import mafrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_W-1:0]     req_event_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RATE_W-1:0]     rsp_frame_rate,
   output logic                  rsp_rate_valid,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              started_ff, started_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] delta_ff, delta_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [TIME_W-1:0] tps_ff, tps_in;
   logic [RATE_W-1:0] res_rate_ff, res_rate_in;
   logic              res_valid_ff, res_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rsp_rate_ff;
   logic              rsp_rv_ff;
   logic              rsp_load;

   logic [TIME_W-1:0] delta_calc;
   logic [CNT_W-1:0]  win_n;
   logic [CNT_W-1:0]  ptr_next;
   logic [TIME_W-1:0] old_interval;
   logic [TIME_W-1:0] rd_data;
   logic [PROD_W-1:0] product;
   logic [DIV_W-1:0]  quotient;
   div_ctl_type       div_ctl;
   div_sts_type       div_sts;

   // Clamp the window size to 1..MAX_SAMPLES
   always_comb begin
      if (win_ff == '0) begin
         win_n = CNT_W'(1);
      end else if (32'(win_ff) > 32'(MAX_SAMPLES)) begin
         win_n = CNT_W'(MAX_SAMPLES);
      end else begin
         win_n = CNT_W'(win_ff);
      end
   end

   assign delta_calc   = req_event_time - last_ff;
   assign ptr_next     = CNT_W'(ptr_ff) + 1'b1;
   assign old_interval = (CNT_W'(ptr_ff) < fill_ff) ? rd_data : '0;
   assign product      = PROD_W'(win_n) * PROD_W'(tps_ff);
   assign div_ctl.start = (state_ff == ST_START);
   assign rsp_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Interval ring store
   mafrm_ram #(
      .WIDTH(TIME_W),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (ptr_ff),
      .wr_data (delta_ff),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Divider: numerator over window sum
   mafrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (num_ff),
      .divisor  (sum_ff),
      .sts      (div_sts),
      .quotient (quotient)
   );

   // Sequencer and window update
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      last_in      = last_ff;
      delta_in     = delta_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      win_in       = win_ff;
      tps_in       = tps_ff;
      res_rate_in  = res_rate_ff;
      res_valid_in = res_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               started_in   = 1'b1;
               last_in      = req_event_time;
               delta_in     = delta_calc;
               res_rate_in  = '0;
               res_valid_in = 1'b0;
               // First event or zero delta: report invalid, keep the window
               if (!started_ff || delta_calc == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            // Replace the oldest interval and advance the pointer
            sum_in = sum_ff - SUM_W'(old_interval) + SUM_W'(delta_ff);
            if (CNT_W'(ptr_ff) == fill_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            if (ptr_next >= win_n) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_next[PTR_W-1:0];
            end
            num_in   = DIV_W'({product, {FRAC_W{1'b0}}});
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_sts.done) begin
               // Saturate the quotient to the output width
               if (|quotient[DIV_W-1:RATE_W]) begin
                  res_rate_in = {RATE_W{1'b1}};
               end else begin
                  res_rate_in = quotient[RATE_W-1:0];
               end
               res_valid_in = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a window size write clears the window
      if (csr_write_en) begin
         if (csr_index == REG_WINDOW_SIZE) begin
            win_in  = csr_wdata[WIN_W-1:0];
            ptr_in  = '0;
            fill_in = '0;
            sum_in  = '0;
         end else if (csr_index == REG_TICKS_PER_SECOND) begin
            tps_in = csr_wdata[TIME_W-1:0];
         end
      end
   end

   // Output register: load from the finished result, drop on handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         last_ff      <= '0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         win_ff       <= WINDOW_RESET;
         tps_ff       <= TICKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         last_ff      <= last_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         win_ff       <= win_in;
         tps_ff       <= tps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      delta_ff     <= delta_in;
      num_ff       <= num_in;
      res_rate_ff  <= res_rate_in;
      res_valid_ff <= res_valid_in;
      if (rsp_load) begin
         rsp_rate_ff <= res_rate_ff;
         rsp_rv_ff   <= res_valid_ff;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_rate = rsp_rate_ff;
   assign rsp_rate_valid = rsp_rv_ff;

   // Checks on the window bookkeeping and the sequencer
   `ASSERT_SAME(a_ptr_in_window, clock, reset, 1'b1, CNT_W'(ptr_ff) < win_n)
   `ASSERT_SAME(a_fill_in_window, clock, reset, 1'b1, fill_ff <= win_n)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_SAME(a_div_active_in_wait, clock, reset, div_sts.busy || div_sts.done, state_ff == ST_WAIT)
   `ASSERT_SAME(a_invalid_is_zero, clock, reset, rsp_valid && !rsp_rate_valid,
                rsp_frame_rate == '0)

endmodule

/* dv/mafrm_checker.sv */
// Checker for the moving-average frame rate meter: watches the timestamp, result
// and register ports, predicts each rate from its own window model, and compares.
// Depends on mafrm_pkg for widths and register indexes.
module mafrm_checker
   import mafrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [TIME_W-1:0]     req_event_time,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [RATE_W-1:0]     rsp_frame_rate,
   input  logic                  rsp_rate_valid,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count
);

   typedef struct packed {
      logic [RATE_W-1:0] frame_rate;
      logic              rate_valid;
   } rate_result_type;

   localparam logic [63:0] RATE_LIMIT = (64'd1 << RATE_W) - 64'd1;

   // Shadow copy of the registers and the interval window
   logic [WIN_W-1:0]  window_cfg;
   logic [TIME_W-1:0] tick_rate_cfg;
   logic [TIME_W-1:0] interval_copy [MAX_SAMPLES];
   int unsigned       slot_ptr;
   logic [63:0]       interval_sum;
   logic [TIME_W-1:0] prev_stamp;
   logic              stamp_latched;

   rate_result_type   expected_rates [$];
   rate_result_type   oldest_rate;
   rate_result_type   predicted_rate;

   // Empty the window: all slots zero, sum zero, pointer at the first slot
   task automatic clear_intervals();
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         interval_copy[i] = '0;
      end
      slot_ptr     = 0;
      interval_sum = '0;
   endtask

   // Fold one timestamp into the window and work out the rate it reports
   task automatic advance_window(input logic [TIME_W-1:0] stamp,
                                 output rate_result_type res);
      logic [TIME_W-1:0] delta;
      int unsigned       depth;
      logic [63:0]       numer;
      logic [63:0]       quot;
      res = '0;
      if (!stamp_latched) begin
         stamp_latched = 1'b1;
         prev_stamp    = stamp;
         return;
      end
      delta      = stamp - prev_stamp;
      prev_stamp = stamp;
      if (delta == '0) return;
      // Clamp the window size into 1..MAX_SAMPLES
      if (window_cfg == '0) depth = 1;
      else if (window_cfg > MAX_SAMPLES) depth = MAX_SAMPLES;
      else depth = 32'(window_cfg);
      if (slot_ptr >= depth) slot_ptr = 0;
      interval_sum = interval_sum - 64'(interval_copy[slot_ptr]) + 64'(delta);
      interval_copy[slot_ptr] = delta;
      slot_ptr = slot_ptr + 1;
      if (slot_ptr >= depth) slot_ptr = 0;
      numer = 64'(depth) * 64'(tick_rate_cfg) * 64'd256;
      quot  = numer / interval_sum;
      if (quot > RATE_LIMIT) quot = RATE_LIMIT;
      res.frame_rate = quot[RATE_W-1:0];
      res.rate_valid = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_cfg    = WINDOW_RESET;
         tick_rate_cfg = TICKS_RESET;
         clear_intervals();
         prev_stamp    = '0;
         stamp_latched = 1'b0;
         expected_rates.delete();
         fail_count    = 0;
         checked_count = 0;
         pending_count <= 0;
      end else begin
         // Track register writes
         if (csr_write_en) begin
            if (csr_index == REG_WINDOW_SIZE) begin
               window_cfg = csr_wdata[WIN_W-1:0];
               clear_intervals();
            end else if (csr_index == REG_TICKS_PER_SECOND) begin
               tick_rate_cfg = csr_wdata[TIME_W-1:0];
            end
         end
         // Compare a result transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_rates.size() == 0) begin
               $display("%0t: result with nothing expected, got rate %h valid %b",
                        $time, rsp_frame_rate, rsp_rate_valid);
               fail_count++;
            end else begin
               oldest_rate = expected_rates[0];
               expected_rates.delete(0);
               checked_count++;
               if (rsp_frame_rate !== oldest_rate.frame_rate) begin
                  $display("%0t: frame_rate mismatch, expected %h, got %h",
                           $time, oldest_rate.frame_rate, rsp_frame_rate);
                  fail_count++;
               end
               if (rsp_rate_valid !== oldest_rate.rate_valid) begin
                  $display("%0t: rate_valid mismatch, expected %b, got %b",
                           $time, oldest_rate.rate_valid, rsp_rate_valid);
                  fail_count++;
               end
            end
         end
         // Predict on each accepted timestamp transaction
         if (req_valid && req_ready) begin
            advance_window(req_event_time, predicted_rate);
            expected_rates = {expected_rates, predicted_rate};
         end
         pending_count <= expected_rates.size();
      end
   end

endmodule

/* dv/tb_top.sv */
// Top of the frame rate meter testbench: clock, reset, timestamp stimulus,
// register settings, result back-pressure and the verdict.
// Depends on mafrm_pkg, the meter RTL and mafrm_checker.
module tb_top;
   import mafrm_pkg::*;

   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int DRAIN_CYCLES = 60;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [TIME_W-1:0]     req_event_time;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [RATE_W-1:0]     rsp_frame_rate;
   logic                  rsp_rate_valid;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    pending_count;
   int                    checked_count;

   logic [TIME_W-1:0]     last_sent;
   int                    sent_items;
   int                    setting_count;
   bit                    quiet;
   int                    stall_left;

   moving_average_frame_rate_meter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_time (req_event_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_rate (rsp_frame_rate),
      .rsp_rate_valid (rsp_rate_valid),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   mafrm_checker rate_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_time (req_event_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_rate (rsp_frame_rate),
      .rsp_rate_valid (rsp_rate_valid),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(1, 3);
   endfunction

   // Frame intervals: mostly ordinary, with zero, tiny, huge and arbitrary ones mixed in
   function automatic logic [TIME_W-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         2: return $urandom_range(1, 16);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom_range(1000, 40000);
      endcase
   endfunction

   // Hold off the result channel at random, releasing it after each stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one timestamp transaction and hold it until accepted
   task automatic send_stamp(input logic [TIME_W-1:0] stamp);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_event_time <= stamp;
      last_sent = stamp;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic step_by(input logic [TIME_W-1:0] delta);
      send_stamp(last_sent + delta);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index    <= idx;
      csr_wdata    <= data;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Apply a new setting once the block has gone idle
   task automatic set_config(input bit touch_window, input logic [CSR_DATA_W-1:0] window_data,
                             input logic [CSR_DATA_W-1:0] tick_rate);
      wait_idle();
      if (touch_window) write_reg(REG_WINDOW_SIZE, window_data);
      write_reg(REG_TICKS_PER_SECOND, tick_rate);
      setting_count++;
   endtask

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int          phase_len;
      logic [8:0]  window_pick;
      logic [31:0] tick_pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_event_time = '0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      last_sent      = '0;
      sent_items     = 0;
      setting_count  = 0;
      quiet          = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: first event, wrap, zero delta, partly filled window, extreme interval
      send_stamp(32'hFFFF_FFF0);
      send_stamp(32'h0000_0010);
      send_stamp(32'h0000_0010);
      step_by(32'd1);
      step_by(32'hFFFF_FFFF);
      step_by(32'd33);
      // Zero tick rate with a single-slot window
      set_config(1'b1, 32'd1, 32'd0);
      step_by(32'd100);
      step_by(32'd7);
      // Full window at the top tick rate drives the quotient as high as it goes
      set_config(1'b1, 32'd256, 32'hFFFF_FFFF);
      step_by(32'd1);
      step_by(32'd1);
      // Window size zero acts as one
      set_config(1'b1, 32'd0, 32'd1);
      step_by(32'd1);
      step_by(32'd7);
      // Oversized window clamps to the store depth; upper data bits are ignored
      set_config(1'b1, 32'hFFFF_FFFF, 32'd1000);
      step_by(32'd5);
      step_by(32'd5);
      // Sum runs past 32 bits
      set_config(1'b1, 32'd2, 32'd1);
      step_by(32'd3);
      step_by(32'hFFFF_FFFF);
      step_by(32'hFFFF_FFFF);
      // Changing only the tick rate keeps the window contents
      set_config(1'b0, 32'd0, 32'd1000);
      step_by(32'd10);
      step_by(32'd10);

      // Random phases: new setting, then a run of mostly regular frame intervals
      while (sent_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: window_pick = 9'd1;
            1: window_pick = 9'd2;
            2: window_pick = 9'($urandom_range(1, 8));
            3: window_pick = 9'($urandom_range(1, 32));
            4: window_pick = 9'd256;
            5: window_pick = 9'd0;
            6: window_pick = 9'($urandom_range(257, 511));
            default: window_pick = 9'($urandom_range(0, 511));
         endcase
         case ($urandom_range(0, 5))
            0: tick_pick = 32'd0;
            1: tick_pick = 32'd1;
            2: tick_pick = 32'd1000;
            3: tick_pick = 32'hFFFF_FFFF;
            4: tick_pick = $urandom;
            default: tick_pick = $urandom_range(1000, 100_000_000);
         endcase
         set_config($urandom_range(0, 2) != 0, {23'($urandom), window_pick}, tick_pick);
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(260, 320)
                                                 : $urandom_range(30, 120);
         for (int i = 0; i < phase_len && sent_items < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 19) == 0) send_stamp($urandom);
            else step_by(pick_interval());
         end
      end

      // Drain and let the pipeline settle
      wait_idle();
      quiet = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d timestamp transactions sent, %0d results checked, %0d settings",
               sent_items, checked_count, setting_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/mafrm_pkg.sv
sv/mafrm_ram.sv
sv/mafrm_div.sv
sv/moving_average_frame_rate_meter.sv
dv/mafrm_checker.sv
dv/tb_top.sv
